>>> rtl/ott_pkg.sv
package ott_pkg;

    localparam int MAX_RX_ANTENNAS = 2;
    // Antennas carried by the input transaction.
    localparam int ANT_LANES = 2;
    localparam int COMP_LANES = 2 * ANT_LANES;

    localparam int SAMPLE_W = 16;
    localparam int HALF_SQ_W = 30;
    localparam int POWER_W = 32;
    localparam int POS_W = 10;
    localparam int COEF_W = 15;
    localparam int ANT_W = 2;
    localparam int HYST_W = 8;
    localparam int FRAME_W = 19;
    localparam int PROD_W = POS_W + COEF_W;
    localparam int CMP_W = POS_W + 1;
    localparam int STEP_W = FRAME_W + 2;

    localparam int TDATA_IN_W = COMP_LANES * SAMPLE_W;
    localparam int TDATA_OUT_W = 40;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = FRAME_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [COEF_W-1:0] COEF_FULL = 15'd32767;
    localparam int FILT_SHIFT = 15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_COEF    = 3'd0,
        CFG_RX_ANTENNAS    = 3'd1,
        CFG_PREFIX_SAMPLES = 3'd2,
        CFG_HYSTERESIS     = 3'd3,
        CFG_FRAME_LENGTH   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0]  filter_coef;
        logic [ANT_W-1:0]   rx_antennas;
        logic [POS_W-1:0]   prefix_samples;
        logic [HYST_W-1:0]  hysteresis;
        logic [FRAME_W-1:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] peak_index;
        logic             clear;
    } frame_t;

endpackage

>>> rtl/ofdm_timing_tracker_top.sv
// A tlast transaction passes s1, s2, the frame queue and states MUL, FILT, STEP
// and WRAP before its result is on m_tvalid. It takes one sample per cycle unless
// a frame end meets a full queue; a 2-entry frame queue holds pending frame ends.
// Reset (rst_n, asynchronous, active low) restores the register defaults and clears
// the peak search, the filtered position and the timing offset at once.
module ofdm_timing_tracker_top
    import ott_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // re_ant0, im_ant0, re_ant1, im_ant1
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // last_sample
    input  logic                   s_tlast,
    // clear
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // timing_offset, peak_position, filtered_position, zero pad
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    cfg_t   cfg_reg;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    frame_t q_wdata;
    frame_t q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_coef    <= COEF_W'(16384);
            cfg_reg.rx_antennas    <= ANT_W'(1);
            cfg_reg.prefix_samples <= POS_W'(144);
            cfg_reg.hysteresis     <= HYST_W'(1);
            cfg_reg.frame_length   <= FRAME_W'(307200);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FILTER_COEF:    cfg_reg.filter_coef    <= cfg_data[COEF_W-1:0];
                CFG_RX_ANTENNAS:    cfg_reg.rx_antennas    <= cfg_data[ANT_W-1:0];
                CFG_PREFIX_SAMPLES: cfg_reg.prefix_samples <= cfg_data[POS_W-1:0];
                CFG_HYSTERESIS:     cfg_reg.hysteresis     <= cfg_data[HYST_W-1:0];
                CFG_FRAME_LENGTH:   cfg_reg.frame_length   <= cfg_data[FRAME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ott_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .q_full   (q_full)
    );

    ott_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    ott_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/ott_queue.sv
module ott_queue
    import ott_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t wdata,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output frame_t rdata
);

    frame_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid = (count_reg != '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("frame queue popped while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("frame queue count did not follow a push");
`endif

endmodule

>>> rtl/ott_front.sv
module ott_front
    import ott_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_IN_W-1:0] s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tuser,
    output logic                  q_push,
    output frame_t                q_wdata,
    input  logic                  q_full
);

    logic                  s1_valid_reg;
    logic [HALF_SQ_W-1:0]  s1_half_reg [COMP_LANES];
    logic                  s1_last_reg;
    logic                  s1_clear_reg;
    logic                  s2_valid_reg;
    logic [POWER_W-1:0]    s2_power_reg;
    logic                  s2_last_reg;
    logic                  s2_clear_reg;
    logic [POWER_W-1:0]    peak_power_reg;
    logic [POWER_W-1:0]    peak_power_next;
    logic [POS_W-1:0]      peak_index_reg;
    logic [POS_W-1:0]      peak_index_next;
    logic [POS_W-1:0]      sample_count_reg;
    logic [POS_W-1:0]      sample_count_next;
    logic [HALF_SQ_W-1:0]  half_sq [COMP_LANES];
    logic [ANT_W-1:0]      ants_cap;
    logic [POWER_W-1:0]    power_sum;
    logic                  adv;
    logic                  upd;
    logic                  hit;
    logic [POS_W-1:0]      idx_new;

    // The pipeline only stops when a frame end cannot enter the full queue.
    assign adv      = !(s2_valid_reg && s2_last_reg && q_full);
    assign s_tready = adv;

    assign ants_cap = (cfg.rx_antennas > ANT_W'(MAX_RX_ANTENNAS))
                      ? ANT_W'(MAX_RX_ANTENNAS) : cfg.rx_antennas;

    always_comb
    begin
        logic signed [SAMPLE_W-1:0]   smp;
        logic signed [2*SAMPLE_W-1:0] sq;
        for (int k = 0; k < COMP_LANES; k++)
        begin
            smp = s_tdata[k*SAMPLE_W +: SAMPLE_W];
            sq  = smp * smp;
            if (int'(ants_cap) > (k / 2))
            begin
                half_sq[k] = sq[HALF_SQ_W:1];
            end
            else
            begin
                half_sq[k] = '0;
            end
        end
    end

    always_comb
    begin
        power_sum = '0;
        for (int k = 0; k < COMP_LANES; k++)
        begin
            power_sum = power_sum + POWER_W'(s1_half_reg[k]);
        end
    end

    assign upd     = s2_valid_reg && adv;
    assign hit     = (sample_count_reg < cfg.prefix_samples) && (s2_power_reg > peak_power_reg);
    assign idx_new = hit ? sample_count_reg : peak_index_reg;
    assign q_push  = upd && s2_last_reg;
    assign q_wdata = '{peak_index: idx_new, clear: s2_clear_reg};

    always_comb
    begin
        peak_power_next   = peak_power_reg;
        peak_index_next   = peak_index_reg;
        sample_count_next = sample_count_reg;
        if (upd)
        begin
            if (s2_last_reg)
            begin
                peak_power_next   = '0;
                peak_index_next   = '0;
                sample_count_next = '0;
            end
            else
            begin
                if (hit)
                begin
                    peak_power_next = s2_power_reg;
                end
                peak_index_next = idx_new;
                if (sample_count_reg != '1)
                begin
                    sample_count_next = sample_count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_half_reg  <= half_sq;
            s1_last_reg  <= s_tlast;
            s1_clear_reg <= s_tuser;
            s2_power_reg <= power_sum;
            s2_last_reg  <= s1_last_reg;
            s2_clear_reg <= s1_clear_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            peak_power_reg   <= '0;
            peak_index_reg   <= '0;
            sample_count_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= s_tvalid;
                s2_valid_reg <= s1_valid_reg;
            end
            peak_power_reg   <= peak_power_next;
            peak_index_reg   <= peak_index_next;
            sample_count_reg <= sample_count_next;
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("frame end pushed into a full queue");
`endif

endmodule

>>> rtl/ott_back.sv
module ott_back
    import ott_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   q_valid,
    input  frame_t                 q_rdata,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_FILT = 5'b00100,
        ST_STEP = 5'b01000,
        ST_WRAP = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [POS_W-1:0]           peak_reg;
    logic                       clear_reg;
    logic [PROD_W-1:0]          prod_old_reg;
    logic [PROD_W-1:0]          prod_new_reg;
    logic [POS_W-1:0]           filt_reg;
    logic [FRAME_W-1:0]         rx_timing_reg;
    logic signed [STEP_W-1:0]   t_reg;
    logic                       out_valid_reg;
    logic [TDATA_OUT_W-1:0]     out_data_reg;
    logic                       out_free;
    logic [PROD_W:0]            filt_sum;
    logic [CMP_W-1:0]           target;
    logic [CMP_W-1:0]           hyst;
    logic [CMP_W-1:0]           filt_ext;
    logic                       step_up;
    logic                       step_down;
    logic signed [STEP_W-1:0]   fl;
    logic signed [STEP_W-1:0]   t1;
    logic signed [STEP_W-1:0]   t2;
    logic signed [STEP_W-1:0]   t3;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign filt_sum = (PROD_W+1)'(prod_old_reg) + (PROD_W+1)'(prod_new_reg);

    assign target    = CMP_W'(cfg.prefix_samples >> 3);
    assign hyst      = CMP_W'(cfg.hysteresis);
    assign filt_ext  = CMP_W'(filt_reg);
    assign step_up   = filt_ext > (target + hyst);
    assign step_down = (filt_ext + hyst) < target;

    // A zero frame length behaves as a length of one.
    assign fl = (cfg.frame_length == '0) ? STEP_W'(1) : $signed(STEP_W'(cfg.frame_length));

    always_comb
    begin
        t1 = (t_reg < 0) ? (t_reg + fl) : t_reg;
        t2 = (t1 >= fl) ? (t1 - fl) : t1;
        t3 = ((t2 >= fl) || (t2 < 0)) ? '0 : t2;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_FILT;
            ST_FILT: state_next = ST_STEP;
            ST_STEP: state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            peak_reg  <= q_rdata.peak_index;
            clear_reg <= q_rdata.clear;
        end
        if (state_reg == ST_MUL)
        begin
            prod_old_reg <= PROD_W'(filt_reg * cfg.filter_coef);
            prod_new_reg <= PROD_W'(peak_reg * (COEF_FULL - cfg.filter_coef));
        end
        if (state_reg == ST_STEP)
        begin
            if (step_up)
            begin
                t_reg <= $signed(STEP_W'(rx_timing_reg)) + STEP_W'(1);
            end
            else if (step_down)
            begin
                t_reg <= $signed(STEP_W'(rx_timing_reg)) - STEP_W'(1);
            end
            else
            begin
                t_reg <= $signed(STEP_W'(rx_timing_reg));
            end
        end
        if ((state_reg == ST_WRAP) && out_free)
        begin
            out_data_reg <= TDATA_OUT_W'({filt_reg, peak_reg, t3[FRAME_W-1:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            filt_reg      <= '0;
            rx_timing_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FILT)
            begin
                filt_reg <= clear_reg ? peak_reg : filt_sum[FILT_SHIFT +: POS_W];
            end
            if ((state_reg == ST_WRAP) && out_free)
            begin
                rx_timing_reg <= t3[FRAME_W-1:0];
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_result_from_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid && !m_tready) && $past(rst_n))
            |-> $past(state_reg == ST_WRAP))
        else $error("result appeared without finishing a frame update");
`endif

endmodule
